[rtl/local_constant_folder_defines.svh]
// ---------------------------------------------------------------------------
// Local constant folder assertion macros
// Shared concurrent assertion forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef LOCAL_CONSTANT_FOLDER_DEFINES_SVH
`define LOCAL_CONSTANT_FOLDER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("local_constant_folder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("local_constant_folder: next-cycle check failed");

`endif

[rtl/lcf_pkg.sv]
// ---------------------------------------------------------------------------
// Local constant folder package
// Opcode and operand kind codes, table and arithmetic unit types and epoch constants.
// ---------------------------------------------------------------------------
package lcf_pkg;

    localparam logic [3:0] CLS_NOP     = 4'd0;
    localparam logic [3:0] CLS_MOV     = 4'd1;
    localparam logic [3:0] CLS_ADD     = 4'd2;
    localparam logic [3:0] CLS_SUB     = 4'd3;
    localparam logic [3:0] CLS_MUL     = 4'd4;
    localparam logic [3:0] CLS_DIV     = 4'd5;
    localparam logic [3:0] CLS_AND     = 4'd6;
    localparam logic [3:0] CLS_OR      = 4'd7;
    localparam logic [3:0] CLS_XOR     = 4'd8;
    localparam logic [3:0] CLS_SHL     = 4'd9;
    localparam logic [3:0] CLS_SHR     = 4'd10;
    localparam logic [3:0] CLS_SAR     = 4'd11;
    localparam logic [3:0] CLS_CMP     = 4'd12;
    localparam logic [3:0] CLS_BARRIER = 4'd13;
    localparam logic [3:0] CLS_OTHER   = 4'd14;

    localparam logic [1:0] KIND_REG = 2'd0;
    localparam logic [1:0] KIND_IMM = 2'd1;

    localparam logic [3:0] REG_IMM_TOTAL = 4'd2;
    localparam logic [5:0] SHIFT_MASK    = 6'd63;

    localparam int unsigned EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

    // Write request from the control path into the constant table.
    typedef struct packed {
        logic        en;
        logic        known;
        logic [63:0] value;
    } t_tbl_wr;

    // Lookup result, valid in the cycle after the address was presented.
    typedef struct packed {
        logic        known;
        logic [63:0] value;
    } t_tbl_rd;

    // Command and completion between the control path and the arithmetic unit.
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [63:0] a;
        logic [63:0] b;
    } t_arith_cmd;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } t_arith_rsp;

endpackage

[rtl/lcf_in_if.sv]
// ---------------------------------------------------------------------------
// Instruction input channel
// Valid/ready channel carrying one instruction per transaction.
// ---------------------------------------------------------------------------
interface lcf_in_if;
    logic        valid;
    logic        ready;
    logic        function_start;
    logic [3:0]  op_class;
    logic [3:0]  operand_total;
    logic [1:0]  first_kind;
    logic [15:0] dest_register;
    logic [1:0]  second_kind;
    logic [63:0] second_value;

    modport source (
        output valid, function_start, op_class, operand_total, first_kind,
               dest_register, second_kind, second_value,
        input  ready
    );
    modport sink (
        input  valid, function_start, op_class, operand_total, first_kind,
               dest_register, second_kind, second_value,
        output ready
    );
endinterface

[rtl/lcf_out_if.sv]
// ---------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying one rewritten instruction per transaction.
// ---------------------------------------------------------------------------
interface lcf_out_if;
    logic        valid;
    logic        ready;
    logic        rewritten;
    logic [3:0]  result_class;
    logic [15:0] result_dest;
    logic [63:0] folded_value;

    modport source (
        output valid, rewritten, result_class, result_dest, folded_value,
        input  ready
    );
    modport sink (
        input  valid, rewritten, result_class, result_dest, folded_value,
        output ready
    );
endinterface

[rtl/lcf_table.sv]
// ---------------------------------------------------------------------------
// Constant table
// Register constant memory with epoch tags and a retagging sweep.
// ---------------------------------------------------------------------------
module lcf_table
    import lcf_pkg::*;
#(
    parameter int unsigned REG_SLOTS = 256,
    parameter int unsigned AW        = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [AW-1:0] i_rd_addr,
    input  logic [AW-1:0] i_wr_addr,
    input  t_tbl_wr       i_wr,
    input  logic          i_clear,
    input  logic          i_idle,
    output t_tbl_rd       o_rd,
    output logic          o_busy
);
    localparam int unsigned CW = $clog2(REG_SLOTS + 1);
    localparam int unsigned DW = 1 + EPOCH_W + 64;

    logic [DW-1:0]      mem [REG_SLOTS];
    logic [DW-1:0]      r_rd;
    logic [EPOCH_W-1:0] r_epoch;
    logic               r_sweep;
    logic               r_init;
    logic [CW-1:0]      r_sw_cnt;
    logic               r_sw_wpend;
    logic [AW-1:0]      r_sw_waddr;

    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [DW-1:0]      wr_data;
    logic               sw_more;
    logic               rd_known;
    logic               sw_keep;

    assign sw_more  = (r_sw_cnt != CW'(REG_SLOTS));
    assign rd_known = r_rd[DW-1];
    // A sweep keeps entries written in the last epoch and moves them to epoch zero.
    assign sw_keep  = !r_init && rd_known && (r_rd[DW-2 -: EPOCH_W] == EPOCH_MAX);

    always_comb begin
        rd_addr = i_rd_addr;
        wr_en   = i_wr.en;
        wr_addr = i_wr_addr;
        wr_data = {i_wr.known, r_epoch, i_wr.value};
        if (r_sweep) begin
            rd_addr = r_sw_cnt[AW-1:0];
            wr_en   = r_sw_wpend;
            wr_addr = r_sw_waddr;
            wr_data = {sw_keep, {EPOCH_W{1'b0}}, r_rd[63:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch    <= '0;
            r_sweep    <= 1'b1;
            r_init     <= 1'b1;
            r_sw_cnt   <= '0;
            r_sw_wpend <= 1'b0;
        end else if (r_sweep) begin
            if (sw_more) begin
                r_sw_cnt   <= r_sw_cnt + 1'b1;
                r_sw_wpend <= 1'b1;
                r_sw_waddr <= r_sw_cnt[AW-1:0];
            end else begin
                r_sw_wpend <= 1'b0;
                r_sweep    <= 1'b0;
                r_init     <= 1'b0;
                r_epoch    <= '0;
            end
        end else if (r_epoch == EPOCH_MAX && i_idle) begin
            r_sweep  <= 1'b1;
            r_sw_cnt <= '0;
        end else if (i_clear) begin
            r_epoch <= r_epoch + 1'b1;
        end
    end

    assign o_rd.known = rd_known && (r_rd[DW-2 -: EPOCH_W] == r_epoch);
    assign o_rd.value = r_rd[63:0];
    assign o_busy     = r_sweep || (r_epoch == EPOCH_MAX);
endmodule

[rtl/lcf_arith.sv]
// ---------------------------------------------------------------------------
// Multi-cycle arithmetic unit
// Wrapping 64-bit multiply from 32-bit partial products, restoring divider.
// ---------------------------------------------------------------------------
module lcf_arith
    import lcf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_arith_cmd i_cmd,
    output t_arith_rsp o_rsp
);
    localparam logic [6:0] MUL_LAST = 7'd3;
    localparam logic [6:0] DIV_LAST = 7'd63;

    logic        r_busy;
    logic        r_is_div;
    logic [6:0]  r_cnt;
    logic        r_done;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_acc;
    logic [63:0] r_prod;
    logic [63:0] r_quo;
    logic [64:0] r_rem;

    logic [31:0] m_x;
    logic [31:0] m_y;
    logic [64:0] rem_sh;
    logic        rem_ge;

    always_comb begin
        m_x = r_a[31:0];
        m_y = r_b[31:0];
        case (r_cnt)
            7'd1:    m_x = r_a[63:32];
            7'd2:    m_y = r_b[63:32];
            default: ;
        endcase
    end

    assign rem_sh = {r_rem[63:0], r_quo[63]};
    assign rem_ge = rem_sh >= {1'b0, r_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy   <= 1'b1;
                r_is_div <= i_cmd.is_div;
                r_cnt    <= '0;
                r_a      <= i_cmd.a;
                r_b      <= i_cmd.b;
                r_quo    <= i_cmd.a;
                r_rem    <= '0;
                r_acc    <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_is_div) begin
                    r_quo <= {r_quo[62:0], rem_ge};
                    r_rem <= rem_ge ? rem_sh - {1'b0, r_b} : rem_sh;
                    if (r_cnt == DIV_LAST) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else begin
                    // The product of the previous step lands in the accumulator.
                    r_prod <= m_x * m_y;
                    if (r_cnt == 7'd1) begin
                        r_acc <= r_prod;
                    end else if (r_cnt != 7'd0) begin
                        r_acc <= r_acc + {r_prod[31:0], 32'd0};
                    end
                    if (r_cnt == MUL_LAST) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_is_div ? r_quo : r_acc;
endmodule

[rtl/local_constant_folder.sv]
// ---------------------------------------------------------------------------
// Local constant folder
// Tracks registers holding known constants and folds register,immediate ops.
// ---------------------------------------------------------------------------
// Usage: instructions arrive on i_in and one result leaves on o_out for each
// of them, in order; both are valid/ready channels. A transaction on i_in is
// looked up in the constant table in the next cycle, and a simple instruction
// is finished there. A folded multiply runs on the shared 32-bit multiplier
// and a folded divide on the one bit per cycle divider. The table is a single
// memory with one read and one write port; one instruction is in flight at a
// time, so a lookup never overlaps the write of the previous instruction.
// Clearing the table (barrier or function start) advances an epoch tag
// instead of rewriting the memory. Every 255 clears, and after reset, a sweep
// walks the table while i_in.ready stays low.
// The result sits in an output register; while o_out is stalled the next
// instruction is still accepted and waits in the block until the register is
// free.
// ---------------------------------------------------------------------------
module local_constant_folder
    import lcf_pkg::*;
#(
    parameter int unsigned REG_SLOTS = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lcf_in_if.sink       i_in,
    lcf_out_if.source    o_out
);
    localparam int unsigned AW = (REG_SLOTS > 1) ? $clog2(REG_SLOTS) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WAIT = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [3:0]  r_cls;
    logic [3:0]  r_total;
    logic [1:0]  r_k0;
    logic [15:0] r_dst;
    logic [1:0]  r_k1;
    logic [63:0] r_val;

    logic        r_out_valid;
    logic        r_out_rew;
    logic [3:0]  r_out_cls;
    logic [15:0] r_out_dst;
    logic [63:0] r_out_val;
    logic        r_res_rew;
    logic [63:0] r_res_val;

    t_tbl_wr     tbl_wr;
    t_tbl_rd     tbl_rd;
    logic        tbl_busy;
    t_arith_cmd  ar_cmd;
    t_arith_rsp  ar_rsp;

    logic        accept;
    logic        out_free;
    logic        is_alu;
    logic        reg_imm;
    logic        tracked;
    logic        fold_ok;
    logic        need_ar;
    logic [63:0] fold_val;
    logic        fin;
    logic        fin_rew;
    logic [63:0] fin_val;

    assign i_in.ready = (r_state == S_IDLE) && !tbl_busy;
    assign accept     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    lcf_table #(
        .REG_SLOTS (REG_SLOTS),
        .AW        (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (i_in.dest_register[AW-1:0]),
        .i_wr_addr (r_dst[AW-1:0]),
        .i_wr      (tbl_wr),
        .i_clear   (accept && (i_in.function_start || i_in.op_class == CLS_BARRIER)),
        .i_idle    (r_state == S_IDLE),
        .o_rd      (tbl_rd),
        .o_busy    (tbl_busy)
    );

    lcf_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (ar_cmd),
        .o_rsp   (ar_rsp)
    );

    always_comb begin
        is_alu  = r_cls inside {[CLS_ADD:CLS_SAR]};
        reg_imm = (r_total == REG_IMM_TOTAL) && (r_k0 == KIND_REG) && (r_k1 == KIND_IMM);
        tracked = 32'(r_dst) < REG_SLOTS;
        fold_ok = is_alu && reg_imm && tracked && tbl_rd.known &&
                  !(r_cls == CLS_DIV && r_val == 64'd0);
        need_ar = fold_ok && (r_cls == CLS_MUL || r_cls == CLS_DIV);
    end

    always_comb begin
        logic [5:0] sh;
        sh = r_val[5:0] & SHIFT_MASK;
        case (r_cls)
            CLS_ADD: fold_val = tbl_rd.value + r_val;
            CLS_SUB: fold_val = tbl_rd.value - r_val;
            CLS_AND: fold_val = tbl_rd.value & r_val;
            CLS_OR:  fold_val = tbl_rd.value | r_val;
            CLS_XOR: fold_val = tbl_rd.value ^ r_val;
            CLS_SHL: fold_val = tbl_rd.value << sh;
            CLS_SHR: fold_val = tbl_rd.value >> sh;
            CLS_SAR: fold_val = 64'($signed(tbl_rd.value) >>> sh);
            default: fold_val = r_val;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        fin          = 1'b0;
        fin_rew      = 1'b0;
        fin_val      = r_val;
        tbl_wr       = '0;
        ar_cmd.start  = 1'b0;
        ar_cmd.is_div = (r_cls == CLS_DIV);
        ar_cmd.a      = tbl_rd.value;
        ar_cmd.b      = r_val;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_cls == CLS_BARRIER) begin
                    fin = 1'b1;
                end else if (need_ar) begin
                    ar_cmd.start = 1'b1;
                    n_state      = S_WAIT;
                end else if (fold_ok) begin
                    fin          = 1'b1;
                    fin_rew      = 1'b1;
                    fin_val      = fold_val;
                    tbl_wr.en    = 1'b1;
                    tbl_wr.known = 1'b1;
                    tbl_wr.value = fold_val;
                end else begin
                    fin = 1'b1;
                    if (r_cls == CLS_MOV && reg_imm) begin
                        tbl_wr.en    = tracked;
                        tbl_wr.known = 1'b1;
                        tbl_wr.value = r_val;
                    end else if ((r_cls == CLS_MOV || is_alu) && r_total != 4'd0 &&
                                 r_k0 == KIND_REG) begin
                        // Any other write to a tracked register forgets its constant.
                        tbl_wr.en = tracked;
                    end
                end
            end
            S_WAIT: begin
                if (ar_rsp.done) begin
                    fin          = 1'b1;
                    fin_rew      = 1'b1;
                    fin_val      = ar_rsp.result;
                    tbl_wr.en    = 1'b1;
                    tbl_wr.known = 1'b1;
                    tbl_wr.value = ar_rsp.result;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (fin) begin
            n_state = out_free ? S_IDLE : S_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_cls   <= i_in.op_class;
                r_total <= i_in.operand_total;
                r_k0    <= i_in.first_kind;
                r_dst   <= i_in.dest_register;
                r_k1    <= i_in.second_kind;
                r_val   <= i_in.second_value;
            end
            if (fin) begin
                r_res_rew <= fin_rew;
                r_res_val <= fin_val;
            end
            if ((fin || r_state == S_HOLD) && out_free) begin
                r_out_valid <= 1'b1;
                r_out_rew   <= fin ? fin_rew : r_res_rew;
                r_out_cls   <= (fin ? fin_rew : r_res_rew) ? CLS_MOV : r_cls;
                r_out_dst   <= r_dst;
                r_out_val   <= fin ? fin_val : r_res_val;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.rewritten    = r_out_rew;
    assign o_out.result_class = r_out_cls;
    assign o_out.result_dest  = r_out_dst;
    assign o_out.folded_value = r_out_val;
endmodule

[rtl/lcf_checker.sv]
// ---------------------------------------------------------------------------
// Local constant folder port checker
// Concurrent checks on the top-level channels, bound to the top level.
// ---------------------------------------------------------------------------
`include "local_constant_folder_defines.svh"

module lcf_checker
    import lcf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_rewritten,
    input logic [3:0]  i_out_class,
    input logic [63:0] i_out_value
);
    `LCF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `LCF_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_value) && $stable(i_out_rewritten))
    `LCF_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `LCF_ASSERT_SAME(a_rewrite_is_mov, i_clk, i_rst_n, i_out_valid && i_out_rewritten, i_out_class == CLS_MOV)
endmodule

bind local_constant_folder lcf_checker u_lcf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_rewritten (o_out.rewritten),
    .i_out_class     (o_out.result_class),
    .i_out_value     (o_out.folded_value)
);

[test/tb_local_constant_folder.sv]
// ---------------------------------------------------------------------------
// Local constant folder testbench
// Drives instruction transactions with random idling on both channels and
// checks every result against a cycle-free predictor of the constant table.
// ---------------------------------------------------------------------------
module tb_local_constant_folder;
    import lcf_pkg::*;

    localparam int unsigned SLOTS     = 256;
    localparam int unsigned WDOG_MAX  = 20000;

    typedef struct packed {
        logic        start;
        logic [3:0]  cls;
        logic [3:0]  total;
        logic [1:0]  k0;
        logic [15:0] dst;
        logic [1:0]  k1;
        logic [63:0] val;
    } t_instr;

    typedef struct packed {
        logic        rew;
        logic [3:0]  cls;
        logic [15:0] dst;
        logic [63:0] val;
    } t_result;

    class fold_scoreboard;
        bit          known [SLOTS];
        logic [63:0] consts [SLOTS];
        t_result     pending [$];
        int          mismatches;
        int          checked;
        int          folds;

        function bit fold_alu(logic [3:0] cls, logic [63:0] a, logic [63:0] b,
                              output logic [63:0] r);
            logic [5:0] sh;
            sh = b[5:0] & SHIFT_MASK;
            fold_alu = 1'b1;
            case (cls)
                CLS_ADD: r = a + b;
                CLS_SUB: r = a - b;
                CLS_MUL: r = a * b;
                CLS_DIV: begin
                    if (b == 64'd0) fold_alu = 1'b0;
                    else r = a / b;
                end
                CLS_AND: r = a & b;
                CLS_OR:  r = a | b;
                CLS_XOR: r = a ^ b;
                CLS_SHL: r = a << sh;
                CLS_SHR: r = a >> sh;
                CLS_SAR: r = $unsigned($signed(a) >>> sh);
                default: fold_alu = 1'b0;
            endcase
        endfunction

        function void note_instr(t_instr t);
            t_result     e;
            logic [63:0] f;
            bit is_alu, reg_imm, tracked, done;
            is_alu  = t.cls >= CLS_ADD && t.cls <= CLS_SAR;
            reg_imm = t.total == REG_IMM_TOTAL && t.k0 == KIND_REG && t.k1 == KIND_IMM;
            tracked = t.dst < SLOTS;
            done    = 0;
            e.rew = 1'b0; e.cls = t.cls; e.dst = t.dst; e.val = t.val;
            if (t.start) foreach (known[i]) known[i] = 0;
            if (t.cls == CLS_BARRIER) begin
                foreach (known[i]) known[i] = 0;
            end else begin
                if (is_alu && reg_imm && tracked && known[t.dst]) begin
                    if (fold_alu(t.cls, consts[t.dst], t.val, f)) begin
                        e.rew = 1'b1; e.cls = CLS_MOV; e.val = f;
                        consts[t.dst] = f;
                        done = 1;
                        folds++;
                    end
                end
                if (!done && t.cls == CLS_MOV && reg_imm) begin
                    if (tracked) begin
                        known[t.dst]  = 1;
                        consts[t.dst] = t.val;
                    end
                    done = 1;
                end
                if (!done && (t.cls == CLS_MOV || is_alu) && t.total != 0
                    && t.k0 == KIND_REG && tracked)
                    known[t.dst] = 0;
            end
            pending.push_back(e);
        endfunction

        function void check_result(t_result got);
            t_result e;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p actual %p", e, got);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    lcf_in_if  in_ch ();
    lcf_out_if out_ch ();

    local_constant_folder #(.REG_SLOTS(SLOTS)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    fold_scoreboard folds_sb;
    int  src_idle_pct;
    int  snk_idle_pct;
    int  wdog;
    int  sent;
    bit  timed_out;
    logic [15:0] hot_regs [4];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random ready, results checked at the edge they are taken.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            folds_sb.check_result({out_ch.rewritten, out_ch.result_class,
                                   out_ch.result_dest, out_ch.folded_value});
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
    end

    initial begin
        wait (wdog >= WDOG_MAX);
        $display("watchdog expired");
        $display("simulation failed");
        $finish;
    end

    // Valid stays high between back-to-back transactions and drops only
    // while the sender idles.
    task automatic send_instr(t_instr t);
        if ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_ch.valid          <= 1'b1;
        in_ch.function_start <= t.start;
        in_ch.op_class       <= t.cls;
        in_ch.operand_total  <= t.total;
        in_ch.first_kind     <= t.k0;
        in_ch.dest_register  <= t.dst;
        in_ch.second_kind    <= t.k1;
        in_ch.second_value   <= t.val;
        do @(posedge i_clk); while (!in_ch.ready);
        folds_sb.note_instr(t);
        sent++;
    endtask

    function automatic t_instr make_instr(logic [3:0] cls, logic [15:0] dst,
                                          logic [63:0] val);
        t_instr t;
        t.start = 1'b0; t.cls = cls; t.total = REG_IMM_TOTAL;
        t.k0 = KIND_REG; t.dst = dst; t.k1 = KIND_IMM; t.val = val;
        return t;
    endfunction

    function automatic logic [63:0] rand_imm(logic [3:0] cls);
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(5))
            0: v = 64'd0;
            1: v = '1;
            2: v = {1'b1, 63'd0};
            3: v = 64'($urandom_range(70));
            default: ;
        endcase
        if (cls == CLS_DIV && $urandom_range(5) != 0 && v > 64'hFFFF) v = 64'(v[15:0]);
        return v;
    endfunction

    task automatic run_directed();
        t_instr t;
        logic [3:0] c;
        send_instr(make_instr(CLS_MOV, 16'd3, 64'hFFFF_FFFF_FFFF_FFFF));
        for (c = CLS_ADD; c <= CLS_SAR; c++)
            send_instr(make_instr(c, 16'd3, (c == CLS_DIV) ? 64'd3 : 64'd5));
        send_instr(make_instr(CLS_MOV, 16'd255, {1'b1, 63'd7}));
        send_instr(make_instr(CLS_SAR, 16'd255, 64'd127));
        send_instr(make_instr(CLS_DIV, 16'd255, 64'd0));     // divide by zero
        send_instr(make_instr(CLS_ADD, 16'd255, 64'd1));     // now unknown
        send_instr(make_instr(CLS_MOV, 16'd256, 64'd9));     // untracked
        send_instr(make_instr(CLS_ADD, 16'hFFFF, 64'd1));
        send_instr(make_instr(CLS_MOV, 16'd0, 64'd0));
        t = make_instr(CLS_ADD, 16'd0, 64'd1); t.total = 4'd3;   // shape mismatch
        send_instr(t);
        send_instr(make_instr(CLS_MOV, 16'd0, 64'd4));
        t = make_instr(CLS_MOV, 16'd0, 64'd2); t.k1 = KIND_REG;  // mov reg,reg
        send_instr(t);
        send_instr(make_instr(CLS_MOV, 16'd1, 64'd8));
        send_instr(make_instr(CLS_CMP, 16'd1, 64'd1));
        send_instr(make_instr(CLS_BARRIER, 16'd1, 64'd1));
        send_instr(make_instr(CLS_SHL, 16'd1, 64'd1));
        send_instr(make_instr(CLS_MOV, 16'd2, 64'd8));
        t = make_instr(CLS_ADD, 16'd2, 64'd1); t.start = 1'b1;
        send_instr(t);
        t = make_instr(4'd15, 16'd2, 64'd1); t.total = 4'd15; t.k0 = 2'd3; t.k1 = 2'd3;
        send_instr(t);
    endtask

    task automatic run_random(int count);
        t_instr t;
        int r;
        repeat (count) begin
            r = $urandom_range(99);
            t.cls = 4'($urandom_range(CLS_ADD, CLS_SAR));
            t = make_instr(t.cls, hot_regs[$urandom_range(3)], 64'd0);
            t.val = rand_imm(t.cls);
            if (r < 25) begin
                t.cls = CLS_MOV;
                if ($urandom_range(3) == 0) t.dst = 16'($urandom_range(SLOTS - 1));
            end else if (r < 80) begin
                // well-formed fold candidate on a hot register
            end else begin
                t.start = ($urandom_range(15) == 0);
                t.cls   = 4'($urandom_range(15));
                t.total = 4'($urandom_range(15));
                t.k0    = 2'($urandom_range(3));
                t.k1    = 2'($urandom_range(3));
                t.dst   = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(SLOTS));
                t.val   = {$urandom, $urandom};
            end
            if ($urandom_range(40) == 0) t.start = 1'b1;
            if ($urandom_range(60) == 0)
                hot_regs[$urandom_range(3)] = 16'($urandom_range(SLOTS - 1));
            send_instr(t);
        end
    endtask

    initial begin
        folds_sb = new();
        wdog = 0; sent = 0;
        src_idle_pct = 35; snk_idle_pct = 60;
        hot_regs[0] = 16'd0; hot_regs[1] = 16'd17;
        hot_regs[2] = 16'd128; hot_regs[3] = 16'd255;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0; in_ch.function_start = 1'b0; in_ch.op_class = CLS_NOP;
        in_ch.operand_total = '0; in_ch.first_kind = KIND_REG; in_ch.dest_register = '0;
        in_ch.second_kind = KIND_REG; in_ch.second_value = '0;
        out_ch.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random(340);
        src_idle_pct = 60; snk_idle_pct = 35;
        run_random(340);
        src_idle_pct = 0; snk_idle_pct = 0;
        run_random(350);
        in_ch.valid <= 1'b0;
        while (folds_sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("%0d instructions sent, %0d results checked, %0d folded",
                 sent, folds_sb.checked, folds_sb.folds);
        if (folds_sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", folds_sb.mismatches);
            $display("simulation failed");
        end
        $finish;
    end
endmodule

[local_constant_folder.f]
+incdir+rtl
rtl/lcf_pkg.sv
rtl/lcf_in_if.sv
rtl/lcf_out_if.sv
rtl/lcf_table.sv
rtl/lcf_arith.sv
rtl/local_constant_folder.sv
rtl/lcf_checker.sv
test/tb_local_constant_folder.sv
